// File: hdl/touch_pen_sampling_controller_assert.svh
// ----------------------------------------------------------------------------
// Touch pen sampling controller assertion macros
// Concurrent assertion wrappers used by the RTL file that checks itself (tpsc_core).
// ----------------------------------------------------------------------------
`ifndef TOUCH_PEN_SAMPLING_CONTROLLER_ASSERT_SVH
`define TOUCH_PEN_SAMPLING_CONTROLLER_ASSERT_SVH

// Checked only outside reset.
`define TPSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define TPSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tpsc_pkg.sv
// ----------------------------------------------------------------------------
// Touch pen sampling controller package
// Event codes, panel modes and the beat types of both channels.
// ----------------------------------------------------------------------------
package tpsc_pkg;

    localparam int FIELD_BITS = 10;

    typedef enum logic [1:0] {
        CMD_PEN_IRQ   = 2'd0,
        CMD_CONV_DONE = 2'd1,
        CMD_TICK      = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_WAIT_DOWN = 2'd0,
        MODE_WAIT_UP   = 2'd1,
        MODE_AUTO      = 2'd2
    } mode_t;

    typedef struct packed {
        cmd_t                  command;
        logic                  pen_up;
        logic [FIELD_BITS-1:0] x_sample;
        logic [FIELD_BITS-1:0] y_sample;
    } tpsc_in_t;

    typedef struct packed {
        logic [1:0]            touch_mode;
        logic                  start_conversion;
        logic                  point_valid;
        logic [FIELD_BITS-1:0] point_x;
        logic [FIELD_BITS-1:0] point_y;
        logic                  point_pressed;
    } tpsc_out_t;

    // Handshake between the input register and the result register
    typedef struct packed {
        logic item_valid;
        logic advance;
    } tpsc_flow_t;

endpackage

// File: hdl/touch_pen_sampling_controller.sv
// ----------------------------------------------------------------------------
// Touch pen sampling controller
// Resistive panel sequencer with 2^AVERAGE_SHIFT sample averaging and mailbox.
// ----------------------------------------------------------------------------
// One event beat is taken every clock cycle: each beat passes through an input
// register, a single pass of mode, accumulator and mailbox logic that updates
// the state, and a result register that offers its one result beat on m_valid.
// The single state update path between the two registers sets that rate; a
// stalled result side holds both registers and then s_ready.
module touch_pen_sampling_controller #(
    parameter int AVERAGE_SHIFT = 4,
    parameter int COORD_BITS    = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tpsc_pkg::tpsc_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output tpsc_pkg::tpsc_out_t m_payload
);
    import tpsc_pkg::*;

    tpsc_flow_t flow;
    logic       item_valid;
    tpsc_in_t   item;
    tpsc_out_t  res;

    tpsc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .advance    (flow.advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tpsc_core #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT),
        .COORD_BITS    (COORD_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flow    (flow),
        .item    (item),
        .res     (res)
    );

    tpsc_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .res        (res),
        .flow       (flow),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

// File: hdl/tpsc_in_stage.sv
// ----------------------------------------------------------------------------
// Touch pen sampling controller input register
// Holds one event beat until the result register can take its result.
// ----------------------------------------------------------------------------
module tpsc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tpsc_pkg::tpsc_in_t s_payload,
    input  logic              advance,
    output logic              item_valid,
    output tpsc_pkg::tpsc_in_t item
);
    import tpsc_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    tpsc_in_t in_data_reg;

    assign s_ready    = !in_valid_reg || advance;
    assign item_valid = in_valid_reg;
    assign item       = in_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
    end

endmodule

// File: hdl/tpsc_out_stage.sv
// ----------------------------------------------------------------------------
// Touch pen sampling controller result register
// Takes a result whenever it is empty or its beat leaves this cycle.
// ----------------------------------------------------------------------------
module tpsc_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  tpsc_pkg::tpsc_out_t res,
    output tpsc_pkg::tpsc_flow_t flow,
    output logic                m_valid,
    input  logic                m_ready,
    output tpsc_pkg::tpsc_out_t m_payload
);
    import tpsc_pkg::*;

    logic      m_valid_reg;
    logic      m_valid_next;
    tpsc_out_t m_data_reg;
    logic      advance;

    assign advance         = item_valid && (!m_valid_reg || m_ready);
    assign flow.item_valid = item_valid;
    assign flow.advance    = advance;
    assign m_valid         = m_valid_reg;
    assign m_payload       = m_data_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res;
        end
    end

endmodule

// File: hdl/tpsc_core.sv
// ----------------------------------------------------------------------------
// Touch pen sampling controller core
// Panel mode state machine, sample accumulators and one-entry point mailbox.
// ----------------------------------------------------------------------------
`include "touch_pen_sampling_controller_assert.svh"

module tpsc_core #(
    parameter int AVERAGE_SHIFT = 4,
    parameter int COORD_BITS    = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tpsc_pkg::tpsc_flow_t flow,
    input  tpsc_pkg::tpsc_in_t   item,
    output tpsc_pkg::tpsc_out_t  res
);
    import tpsc_pkg::*;

    localparam int SUM_W     = COORD_BITS + AVERAGE_SHIFT;
    localparam int CNT_W     = (AVERAGE_SHIFT > 0) ? AVERAGE_SHIFT : 1;
    localparam int LOW_W     = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int BLOCK_LEN = 1 << AVERAGE_SHIFT;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_LEN - 1);

    mode_t                 mode_reg, mode_next;
    logic                  track_reg, track_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]      x_sum_reg, x_sum_next;
    logic [SUM_W-1:0]      y_sum_reg, y_sum_next;
    logic                  held_valid_reg, held_valid_next;
    logic [FIELD_BITS-1:0] held_x_reg, held_y_reg;
    logic                  held_pressed_reg;

    logic                  fire;
    logic                  last;
    logic [COORD_BITS-1:0] x_m, y_m;
    logic [SUM_W-1:0]      x_sum_add, y_sum_add;
    logic [COORD_BITS-1:0] x_avg, y_avg;
    logic                  post;
    logic                  post_pressed;
    logic [FIELD_BITS-1:0] post_x, post_y;
    logic                  start;
    logic                  read_hit;

    assign fire = flow.advance;
    assign last = (cnt_reg == LAST_CNT);

    // Samples masked to the coordinate width
    always_comb begin
        x_m = '0;
        y_m = '0;
        x_m[LOW_W-1:0] = item.x_sample[LOW_W-1:0];
        y_m[LOW_W-1:0] = item.y_sample[LOW_W-1:0];
    end

    assign x_sum_add = x_sum_reg + SUM_W'(x_m);
    assign y_sum_add = y_sum_reg + SUM_W'(y_m);
    assign x_avg     = x_sum_add[SUM_W-1:AVERAGE_SHIFT];
    assign y_avg     = y_sum_add[SUM_W-1:AVERAGE_SHIFT];

    // Next panel mode
    always_comb begin
        mode_next = mode_reg;
        unique case (item.command)
            CMD_PEN_IRQ: begin
                mode_next = item.pen_up ? MODE_WAIT_DOWN : MODE_AUTO;
            end
            CMD_CONV_DONE: begin
                if (item.pen_up) begin
                    mode_next = MODE_WAIT_DOWN;
                end else if (last) begin
                    mode_next = MODE_WAIT_UP;
                end else begin
                    mode_next = MODE_AUTO;
                end
            end
            CMD_TICK: begin
                if (track_reg && mode_reg != MODE_AUTO) begin
                    mode_next = item.pen_up ? MODE_WAIT_DOWN : MODE_AUTO;
                end
            end
            CMD_READ: begin
                mode_next = mode_reg;
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Outputs and datapath of one step
    always_comb begin
        start        = 1'b0;
        post         = 1'b0;
        post_pressed = 1'b0;
        post_x       = '0;
        post_y       = '0;
        read_hit     = 1'b0;
        track_next   = track_reg;
        cnt_next     = cnt_reg;
        x_sum_next   = x_sum_reg;
        y_sum_next   = y_sum_reg;
        unique case (item.command)
            CMD_PEN_IRQ: begin
                start = !item.pen_up;
                post  = item.pen_up;
            end
            CMD_CONV_DONE: begin
                if (item.pen_up) begin
                    cnt_next   = '0;
                    x_sum_next = '0;
                    y_sum_next = '0;
                    track_next = 1'b0;
                    post       = 1'b1;
                end else if (last) begin
                    cnt_next     = '0;
                    x_sum_next   = '0;
                    y_sum_next   = '0;
                    track_next   = 1'b1;
                    post         = 1'b1;
                    post_pressed = 1'b1;
                    post_x[LOW_W-1:0] = x_avg[LOW_W-1:0];
                    post_y[LOW_W-1:0] = y_avg[LOW_W-1:0];
                end else begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    x_sum_next = x_sum_add;
                    y_sum_next = y_sum_add;
                    start      = 1'b1;
                end
            end
            CMD_TICK: begin
                if (track_reg && mode_reg != MODE_AUTO) begin
                    if (item.pen_up) begin
                        track_next = 1'b0;
                        post       = 1'b1;
                    end else begin
                        start = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                read_hit = held_valid_reg;
            end
            default: begin
                read_hit = 1'b0;
            end
        endcase
    end

    // Mailbox: a post while full is dropped, a read empties it
    always_comb begin
        held_valid_next = held_valid_reg;
        if (read_hit) begin
            held_valid_next = 1'b0;
        end else if (post) begin
            held_valid_next = 1'b1;
        end
    end

    always_comb begin
        res.touch_mode       = mode_next;
        res.start_conversion = start;
        res.point_valid      = read_hit;
        res.point_x          = read_hit ? held_x_reg : '0;
        res.point_y          = read_hit ? held_y_reg : '0;
        res.point_pressed    = read_hit && held_pressed_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_WAIT_DOWN;
            track_reg      <= 1'b0;
            cnt_reg        <= '0;
            x_sum_reg      <= '0;
            y_sum_reg      <= '0;
            held_valid_reg <= 1'b0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            track_reg      <= track_next;
            cnt_reg        <= cnt_next;
            x_sum_reg      <= x_sum_next;
            y_sum_reg      <= y_sum_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && post && !held_valid_reg) begin
            held_x_reg       <= post_x;
            held_y_reg       <= post_y;
            held_pressed_reg <= post_pressed;
        end
    end

    `TPSC_ASSERT(a_start_in_auto, aclk, aresetn, fire && start |=> mode_reg == MODE_AUTO, "conversion started outside auto mode")
    `TPSC_ASSERT(a_point_on_read, aclk, aresetn, fire && read_hit |-> item.command == CMD_READ, "point returned on a non-read beat")
    `TPSC_ASSERT(a_read_empties, aclk, aresetn, fire && item.command == CMD_READ |=> !held_valid_reg, "mailbox still full after read")
    `TPSC_ASSERT(a_release_clears, aclk, aresetn, fire && item.command == CMD_CONV_DONE && item.pen_up |=> cnt_reg == '0 && x_sum_reg == '0 && !track_reg, "release left sums or tracking set")
    `TPSC_ASSERT_ALWAYS(a_fire_needs_item, aclk, fire |-> flow.item_valid, "state advanced without a held beat")

endmodule
